/* src/ddmcf_pkg.sv */
// shared types, widths and constants of the differential-drive modbus framer
// no dependencies
`default_nettype none
package ddmcf_pkg;

   localparam int VEL_W  = 16;
   localparam int SPD_W  = 15;
   localparam int RATE_W = 15;
   localparam int BASE_W = 12;
   localparam int FS_W   = 15;
   localparam int NODE_W = 8;
   localparam int REG_W  = 16;
   localparam int BYTE_W = 8;

   // datapath widths of the scaling arithmetic
   localparam int PROD_W = 32;              // v or w times the turn limit
   localparam int DEN_W  = VEL_W + 1;       // |w|
   localparam int DD_W   = DEN_W + 11;      // 2000 * |w|
   localparam int RN_W   = 45;              // signed wheel numerator
   localparam int MAG_W  = RN_W - 1;        // its magnitude, also the divisor
   localparam int NUM_W  = MAG_W + FS_W;    // magnitude times full scale
   localparam int Q_W    = FS_W;            // quotient never exceeds full scale
   localparam int DRV_W  = 16;
   localparam int DIV_STEPS = Q_W;

   localparam int WHEEL_SCALE = 2000;

   localparam logic [BYTE_W-1:0] FUNC_WRITE_REG  = 8'h06;
   localparam logic [BYTE_W-1:0] FUNC_WRITE_COIL = 8'h05;
   localparam logic [BYTE_W-1:0] ZERO_BYTE       = 8'h00;

   localparam logic [SPD_W-1:0]  RST_MAX_WHEEL_SPEED  = 15'd1000;
   localparam logic [RATE_W-1:0] RST_MAX_TURN_RATE    = 15'd1000;
   localparam logic [BASE_W-1:0] RST_WHEEL_TRACK      = 12'd500;
   localparam logic [FS_W-1:0]   RST_DRIVE_FULL_SCALE = 15'd990;
   localparam logic [NODE_W-1:0] RST_RIGHT_NODE_ADDR  = 8'd2;
   localparam logic [NODE_W-1:0] RST_LEFT_NODE_ADDR   = 8'd1;
   localparam logic [NODE_W-1:0] RST_RELAY_NODE_ADDR  = 8'd4;
   localparam logic [REG_W-1:0]  RST_SPEED_REG_ADDR   = 16'd64;

   typedef enum logic [2:0] {
      REG_MAX_WHEEL_SPEED  = 3'd0,
      REG_MAX_TURN_RATE    = 3'd1,
      REG_WHEEL_TRACK      = 3'd2,
      REG_DRIVE_FULL_SCALE = 3'd3,
      REG_RIGHT_NODE_ADDR  = 3'd4,
      REG_LEFT_NODE_ADDR   = 3'd5,
      REG_RELAY_NODE_ADDR  = 3'd6,
      REG_SPEED_REG_ADDR   = 3'd7
   } ddmcf_reg_type;

   typedef struct packed {
      logic [SPD_W-1:0]  max_wheel_speed;
      logic [RATE_W-1:0] max_turn_rate;
      logic [BASE_W-1:0] wheel_track;
      logic [FS_W-1:0]   drive_full_scale;
      logic [NODE_W-1:0] right_node_addr;
      logic [NODE_W-1:0] left_node_addr;
      logic [NODE_W-1:0] relay_node_addr;
      logic [REG_W-1:0]  speed_reg_addr;
   } ddmcf_cfg_type;

   // coil command fields ride along the velocity pipeline
   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] coil_addr;
      logic [BYTE_W-1:0] coil_value;
   } ddmcf_side_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem_r;
      logic [NUM_W-1:0] rem_l;
      logic [MAG_W-1:0] dvs;
      logic [Q_W-1:0]   q_r;
      logic [Q_W-1:0]   q_l;
      logic             neg_r;
      logic             neg_l;
      logic             zero;
      ddmcf_side_type   side;
   } ddmcf_div_type;

   typedef struct packed {
      ddmcf_side_type   side;
      logic [DRV_W-1:0] drive_r;
      logic [DRV_W-1:0] drive_l;
   } ddmcf_job_type;

endpackage
`default_nettype wire

/* src/ddmcf_front.sv */
// front stages: turn limit, wheel numerators, limit compare and numerator products
// depends on ddmcf_pkg
`default_nettype none
module ddmcf_front
   import ddmcf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_vld,
   input  wire ddmcf_side_type     in_side,
   input  wire logic [VEL_W-1:0]   in_lin_vel,
   input  wire logic [VEL_W-1:0]   in_ang_vel,
   input  wire ddmcf_cfg_type      cfg,
   output ddmcf_div_type           out_item,
   output logic                    out_vld
);

   // stage 1
   logic                     vld1_ff;
   ddmcf_side_type           side1_ff;
   logic signed [PROD_W-1:0] vn1_ff, vn1_in, wn1_ff, wn1_in;
   logic [DEN_W-1:0]         den1_ff, den1_in;
   logic signed [VEL_W-1:0]  lv, av;
   logic signed [DEN_W-1:0]  av_x;
   logic [DEN_W-1:0]         av_mag;
   logic signed [VEL_W:0]    wt_s;
   logic                     lim;

   always_comb begin
      lv     = $signed(in_lin_vel);
      av     = $signed(in_ang_vel);
      av_x   = DEN_W'(av);
      av_mag = av_x[DEN_W-1] ? DEN_W'(-av_x) : DEN_W'(av_x);
      wt_s   = $signed({2'b00, cfg.max_turn_rate});
      lim    = av_mag > DEN_W'(cfg.max_turn_rate);
      if (lim) begin
         vn1_in  = PROD_W'(lv) * PROD_W'(wt_s);
         wn1_in  = PROD_W'(av) * PROD_W'(wt_s);
         den1_in = av_mag;
      end else begin
         vn1_in  = PROD_W'(lv);
         wn1_in  = PROD_W'(av);
         den1_in = DEN_W'(1);
      end
   end

   // stage 2
   logic                   vld2_ff;
   ddmcf_side_type         side2_ff;
   logic signed [RN_W-1:0] rn2_ff, rn2_in, ln2_ff, ln2_in;
   logic signed [RN_W-1:0] v2k, wb;
   logic [DD_W-1:0]        dd2_ff, dd2_in;

   always_comb begin
      v2k    = RN_W'(vn1_ff) * RN_W'(WHEEL_SCALE);
      wb     = RN_W'(wn1_ff) * $signed(RN_W'(cfg.wheel_track));
      rn2_in = v2k + wb;
      ln2_in = v2k - wb;
      dd2_in = DD_W'(den1_ff) * DD_W'(WHEEL_SCALE);
   end

   // stage 3
   logic                   vld3_ff;
   ddmcf_side_type         side3_ff;
   logic [MAG_W-1:0]       mr3_ff, mr3_in, ml3_ff, ml3_in, sdd3_ff, sdd3_in;
   logic                   neg_r3_ff, neg_l3_ff;

   always_comb begin
      mr3_in  = rn2_ff[RN_W-1] ? MAG_W'(-rn2_ff) : MAG_W'(rn2_ff);
      ml3_in  = ln2_ff[RN_W-1] ? MAG_W'(-ln2_ff) : MAG_W'(ln2_ff);
      sdd3_in = MAG_W'(cfg.max_wheel_speed) * MAG_W'(dd2_ff);
   end

   // stage 4: pick the divisor, form the dividends
   logic          vld4_ff;
   ddmcf_div_type item4_ff, item4_in;
   logic          over;

   always_comb begin
      over            = (mr3_ff > sdd3_ff) || (ml3_ff > sdd3_ff);
      item4_in.rem_r  = NUM_W'(mr3_ff) * NUM_W'(cfg.drive_full_scale);
      item4_in.rem_l  = NUM_W'(ml3_ff) * NUM_W'(cfg.drive_full_scale);
      item4_in.dvs    = over ? ((mr3_ff > ml3_ff) ? mr3_ff : ml3_ff) : sdd3_ff;
      item4_in.q_r    = '0;
      item4_in.q_l    = '0;
      item4_in.neg_r  = neg_r3_ff;
      item4_in.neg_l  = neg_l3_ff;
      item4_in.zero   = !over && (sdd3_ff == '0);
      item4_in.side   = side3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (advance) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side1_ff  <= in_side;
         vn1_ff    <= vn1_in;
         wn1_ff    <= wn1_in;
         den1_ff   <= den1_in;
         side2_ff  <= side1_ff;
         rn2_ff    <= rn2_in;
         ln2_ff    <= ln2_in;
         dd2_ff    <= dd2_in;
         side3_ff  <= side2_ff;
         mr3_ff    <= mr3_in;
         ml3_ff    <= ml3_in;
         sdd3_ff   <= sdd3_in;
         neg_r3_ff <= rn2_ff[RN_W-1];
         neg_l3_ff <= ln2_ff[RN_W-1];
         item4_ff  <= item4_in;
      end
   end

   assign out_item = item4_ff;
   assign out_vld  = vld4_ff;

endmodule
`default_nettype wire

/* src/ddmcf_div.sv */
// pipelined restoring divider, one quotient bit per stage for both wheels
// depends on ddmcf_pkg
`default_nettype none
module ddmcf_div
   import ddmcf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_vld,
   input  wire ddmcf_div_type in_item,
   output ddmcf_job_type      out_job,
   output logic               out_vld
);

   function automatic ddmcf_div_type div_step(input ddmcf_div_type x, input int unsigned sh);
      logic [NUM_W:0] d_sh;
      ddmcf_div_type  y;
      y    = x;
      d_sh = (NUM_W+1)'(x.dvs) << sh;
      if ({1'b0, x.rem_r} >= d_sh) begin
         y.rem_r = NUM_W'({1'b0, x.rem_r} - d_sh);
         y.q_r   = x.q_r | (Q_W'(1) << sh);
      end
      if ({1'b0, x.rem_l} >= d_sh) begin
         y.rem_l = NUM_W'({1'b0, x.rem_l} - d_sh);
         y.q_l   = x.q_l | (Q_W'(1) << sh);
      end
      return y;
   endfunction

   ddmcf_div_type stg_ff [DIV_STEPS];
   logic          vld_ff [DIV_STEPS];

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      ddmcf_div_type stg_in;
      logic          vld_in;
      if (g == 0) begin : g_first
         assign stg_in = div_step(in_item, Q_W - 1);
         assign vld_in = in_vld;
      end else begin : g_rest
         assign stg_in = div_step(stg_ff[g-1], Q_W - 1 - g);
         assign vld_in = vld_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (advance) begin
            vld_ff[g] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stg_ff[g] <= stg_in;
         end
      end
   end

   ddmcf_div_type    fin;
   logic [DRV_W-1:0] q_r_x, q_l_x;

   always_comb begin
      fin             = stg_ff[DIV_STEPS-1];
      q_r_x           = DRV_W'(fin.q_r);
      q_l_x           = DRV_W'(fin.q_l);
      out_job.side    = fin.side;
      out_job.drive_r = fin.zero ? '0 : (fin.neg_r ? DRV_W'(-q_r_x) : q_r_x);
      out_job.drive_l = fin.zero ? '0 : (fin.neg_l ? DRV_W'(-q_l_x) : q_l_x);
   end

   assign out_vld = vld_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

/* src/ddmcf_ser.sv */
// frame serializer: builds modbus frame bytes and the running crc-16, one byte per cycle while out_stall is low
// depends on ddmcf_pkg
`default_nettype none
module ddmcf_ser
   import ddmcf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ddmcf_cfg_type      cfg,
   input  wire logic               job_vld,
   input  wire ddmcf_job_type      job,
   output logic                    job_take,
   output logic                    out_vld,
   output logic [BYTE_W-1:0]       out_byte,
   output logic                    out_frame_end,
   output logic                    out_last,
   input  wire logic               out_stall
);

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      end
      return r;
   endfunction

   ddmcf_job_type      job_ff;
   logic               busy_ff;
   logic [3:0]         idx_ff;
   logic [15:0]        crc_ff, crc_in;
   logic               vld_ff;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               end_ff, last_ff;

   logic               load_out, final_byte;
   logic [2:0]         pos;
   logic               second;
   logic [15:0]        crc_src;
   logic [NODE_W-1:0]  node;
   logic [DRV_W-1:0]   drive;

   always_comb begin
      pos        = idx_ff[2:0];
      second     = idx_ff[3];
      load_out   = !vld_ff || !out_stall;
      final_byte = (pos == 3'd7) && (job_ff.side.cmd || second);
      job_take   = !busy_ff || (load_out && final_byte);
      node       = second ? cfg.left_node_addr : cfg.right_node_addr;
      drive      = second ? job_ff.drive_l : job_ff.drive_r;
      byte_in    = ZERO_BYTE;
      if (job_ff.side.cmd) begin
         unique case (pos)
            3'd0: byte_in = cfg.relay_node_addr;
            3'd1: byte_in = FUNC_WRITE_COIL;
            3'd2: byte_in = ZERO_BYTE;
            3'd3: byte_in = job_ff.side.coil_addr;
            3'd4: byte_in = job_ff.side.coil_value;
            3'd5: byte_in = ZERO_BYTE;
            3'd6: byte_in = crc_ff[7:0];
            3'd7: byte_in = crc_ff[15:8];
            default: byte_in = ZERO_BYTE;
         endcase
      end else begin
         unique case (pos)
            3'd0: byte_in = node;
            3'd1: byte_in = FUNC_WRITE_REG;
            3'd2: byte_in = cfg.speed_reg_addr[15:8];
            3'd3: byte_in = cfg.speed_reg_addr[7:0];
            3'd4: byte_in = drive[15:8];
            3'd5: byte_in = drive[7:0];
            3'd6: byte_in = crc_ff[7:0];
            3'd7: byte_in = crc_ff[15:8];
            default: byte_in = ZERO_BYTE;
         endcase
      end
      crc_src = (pos == 3'd0) ? 16'hFFFF : crc_ff;
      crc_in  = crc_byte(crc_src, byte_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         if (busy_ff && load_out) begin
            idx_ff <= idx_ff + 4'd1;
            if (final_byte) begin
               busy_ff <= 1'b0;
            end
         end
         if (job_take && job_vld) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end
         if (load_out) begin
            vld_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_take && job_vld) begin
         job_ff <= job;
      end
      if (busy_ff && load_out) begin
         byte_ff <= byte_in;
         end_ff  <= (pos == 3'd7);
         last_ff <= final_byte;
         if (pos < 3'd6) begin
            crc_ff <= crc_in;
         end
      end
   end

   assign out_vld       = vld_ff;
   assign out_byte      = byte_ff;
   assign out_frame_end = end_ff;
   assign out_last      = last_ff;

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      vld_ff && last_ff |-> end_ff)
      else $error("last byte not on a frame end");

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      job_take && job_vld |=> busy_ff && (idx_ff == 4'd0))
      else $error("taken item did not start at byte zero");

   a_busy_holds: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !load_out |=> busy_ff && $stable(idx_ff))
      else $error("serializer moved while output stalled");

   a_crc_init: assert property (@(posedge clock) disable iff (reset)
      busy_ff && load_out && (pos == 3'd7) |=> (idx_ff[2:0] == 3'd0))
      else $error("frame index did not wrap");

endmodule
`default_nettype wire

/* src/diff_drive_modbus_command_framer_top.sv */
// top level of the differential-drive modbus command framer: csr block and pipeline
// depends on ddmcf_pkg, ddmcf_front, ddmcf_div, ddmcf_ser
`default_nettype none
// A velocity item (req_cmd 0) limits the turn rate, forms both wheel speeds,
// scales them to the wheel limit and converts them to signed 16-bit drive
// values; it yields sixteen bytes: a function-6 frame to the right driver,
// then one to the left, each closed by its crc-16 low byte first. A coil
// item (req_cmd 1) yields one eight-byte function-5 frame. rsp_frame_end
// marks each frame's last crc byte, rsp_last the final byte of the item.
// Items run through four arithmetic stages, a fifteen-stage divider (one
// quotient bit per stage) and the serializer's job and byte registers.
// The serializer sends one byte per cycle while rsp_stall is low, with no
// gap between items. The next item is taken while the current one is still
// being sent. Registers sit at byte address 4*index on the csr port and
// should only be written while no item is in flight.
module diff_drive_modbus_command_framer_top
   import ddmcf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // item input
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [15:0]       req_lin_vel,
   input  wire logic [15:0]       req_ang_vel,
   input  wire logic [7:0]        req_coil_addr,
   input  wire logic [7:0]        req_coil_value,
   // byte stream output
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_frame_end,
   output logic                   rsp_last,
   // register port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [4:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   // configuration registers
   ddmcf_cfg_type cfg_ff;
   ddmcf_reg_type csr_idx;
   logic          csr_we;

   assign csr_idx    = ddmcf_reg_type'(csr_paddr[4:2]);
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_wheel_speed  <= RST_MAX_WHEEL_SPEED;
         cfg_ff.max_turn_rate    <= RST_MAX_TURN_RATE;
         cfg_ff.wheel_track      <= RST_WHEEL_TRACK;
         cfg_ff.drive_full_scale <= RST_DRIVE_FULL_SCALE;
         cfg_ff.right_node_addr  <= RST_RIGHT_NODE_ADDR;
         cfg_ff.left_node_addr   <= RST_LEFT_NODE_ADDR;
         cfg_ff.relay_node_addr  <= RST_RELAY_NODE_ADDR;
         cfg_ff.speed_reg_addr   <= RST_SPEED_REG_ADDR;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_MAX_WHEEL_SPEED:  cfg_ff.max_wheel_speed  <= csr_pwdata[SPD_W-1:0];
            REG_MAX_TURN_RATE:    cfg_ff.max_turn_rate    <= csr_pwdata[RATE_W-1:0];
            REG_WHEEL_TRACK:      cfg_ff.wheel_track      <= csr_pwdata[BASE_W-1:0];
            REG_DRIVE_FULL_SCALE: cfg_ff.drive_full_scale <= csr_pwdata[FS_W-1:0];
            REG_RIGHT_NODE_ADDR:  cfg_ff.right_node_addr  <= csr_pwdata[NODE_W-1:0];
            REG_LEFT_NODE_ADDR:   cfg_ff.left_node_addr   <= csr_pwdata[NODE_W-1:0];
            REG_RELAY_NODE_ADDR:  cfg_ff.relay_node_addr  <= csr_pwdata[NODE_W-1:0];
            REG_SPEED_REG_ADDR:   cfg_ff.speed_reg_addr   <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_MAX_WHEEL_SPEED:  csr_prdata = 32'(cfg_ff.max_wheel_speed);
         REG_MAX_TURN_RATE:    csr_prdata = 32'(cfg_ff.max_turn_rate);
         REG_WHEEL_TRACK:      csr_prdata = 32'(cfg_ff.wheel_track);
         REG_DRIVE_FULL_SCALE: csr_prdata = 32'(cfg_ff.drive_full_scale);
         REG_RIGHT_NODE_ADDR:  csr_prdata = 32'(cfg_ff.right_node_addr);
         REG_LEFT_NODE_ADDR:   csr_prdata = 32'(cfg_ff.left_node_addr);
         REG_RELAY_NODE_ADDR:  csr_prdata = 32'(cfg_ff.relay_node_addr);
         REG_SPEED_REG_ADDR:   csr_prdata = 32'(cfg_ff.speed_reg_addr);
         default:              csr_prdata = '0;
      endcase
   end

   // pipeline: the whole arithmetic chain moves together, and holds only
   // when a finished item sits at the divider output and the serializer is full
   ddmcf_side_type in_side;
   ddmcf_div_type  front_item;
   logic           front_vld;
   ddmcf_job_type  div_job;
   logic           div_vld;
   logic           job_take;
   logic           advance;

   assign advance   = !div_vld || job_take;
   assign req_stall = !advance;

   assign in_side.cmd        = req_cmd;
   assign in_side.coil_addr  = req_coil_addr;
   assign in_side.coil_value = req_coil_value;

   ddmcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_vld     (req_valid),
      .in_side    (in_side),
      .in_lin_vel (req_lin_vel),
      .in_ang_vel (req_ang_vel),
      .cfg        (cfg_ff),
      .out_item   (front_item),
      .out_vld    (front_vld)
   );

   ddmcf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (front_vld),
      .in_item (front_item),
      .out_job (div_job),
      .out_vld (div_vld)
   );

   // byte serializer with its own output register
   ddmcf_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .job_vld       (div_vld),
      .job           (div_job),
      .job_take      (job_take),
      .out_vld       (rsp_valid),
      .out_byte      (rsp_out_byte),
      .out_frame_end (rsp_frame_end),
      .out_last      (rsp_last),
      .out_stall     (rsp_stall)
   );

   a_hold_keeps_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> div_vld)
      else $error("held pipeline lost its finished item");

   a_hold_keeps_job: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(div_job))
      else $error("held pipeline changed its finished item");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> div_vld && !job_take)
      else $error("input held without a full pipeline");

endmodule
`default_nettype wire

/* bench/tb_diff_drive_modbus_command_framer_top.sv */
// testbench of the differential-drive modbus command framer: random and directed items,
// byte-exact frame prediction with crc, apb register phases; depends on ddmcf_pkg and the rtl
`default_nettype none
module tb_diff_drive_modbus_command_framer_top;
   import ddmcf_pkg::*;

   localparam logic CMD_VELOCITY = 1'b0;
   localparam logic CMD_COIL     = 1'b1;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   CYCLE_LIMIT  = 400000;

   // expected frame byte
   typedef struct {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       last;
   } frame_byte_type;

   // frame predictor and store of expected bytes
   class frame_scoreboard;
      logic [SPD_W-1:0]  wheel_lim;
      logic [RATE_W-1:0] turn_lim;
      logic [BASE_W-1:0] base_mm;
      logic [FS_W-1:0]   full_scale;
      logic [NODE_W-1:0] right_node;
      logic [NODE_W-1:0] left_node;
      logic [NODE_W-1:0] relay_node;
      logic [REG_W-1:0]  speed_reg;
      frame_byte_type    pending[$];
      int                errors;

      function new();
         wheel_lim  = RST_MAX_WHEEL_SPEED;
         turn_lim   = RST_MAX_TURN_RATE;
         base_mm    = RST_WHEEL_TRACK;
         full_scale = RST_DRIVE_FULL_SCALE;
         right_node = RST_RIGHT_NODE_ADDR;
         left_node  = RST_LEFT_NODE_ADDR;
         relay_node = RST_RELAY_NODE_ADDR;
         speed_reg  = RST_SPEED_REG_ADDR;
         errors     = 0;
      endfunction

      function void set_reg(ddmcf_reg_type idx, logic [31:0] v);
         case (idx)
            REG_MAX_WHEEL_SPEED:  wheel_lim  = v[SPD_W-1:0];
            REG_MAX_TURN_RATE:    turn_lim   = v[RATE_W-1:0];
            REG_WHEEL_TRACK:      base_mm    = v[BASE_W-1:0];
            REG_DRIVE_FULL_SCALE: full_scale = v[FS_W-1:0];
            REG_RIGHT_NODE_ADDR:  right_node = v[NODE_W-1:0];
            REG_LEFT_NODE_ADDR:   left_node  = v[NODE_W-1:0];
            REG_RELAY_NODE_ADDR:  relay_node = v[NODE_W-1:0];
            REG_SPEED_REG_ADDR:   speed_reg  = v[REG_W-1:0];
            default: ;
         endcase
      endfunction

      // crc-16 appended low byte first
      function void push_frame(logic [7:0] fr[6], logic item_end);
         logic [15:0] crc;
         frame_byte_type e;
         crc = 16'hFFFF;
         for (int i = 0; i < 6; i++) begin
            crc = crc ^ {8'h00, fr[i]};
            for (int k = 0; k < 8; k++)
               crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
         end
         for (int i = 0; i < 8; i++) begin
            e.out_byte  = (i < 6) ? fr[i] : (i == 6 ? crc[7:0] : crc[15:8]);
            e.frame_end = (i == 7);
            e.last      = (i == 7) && item_end;
            pending.push_back(e);
         end
      endfunction

      function void note_item(logic cmd, logic [15:0] lin, logic [15:0] ang,
                              logic [7:0] coil_addr, logic [7:0] coil_value);
         logic [7:0] fr[6];
         longint v, w, den, rn, ln, dd, mr, ml, s, top;
         logic [15:0] dr, dl;
         if (cmd == CMD_COIL) begin
            fr = '{relay_node, FUNC_WRITE_COIL, ZERO_BYTE, coil_addr, coil_value, ZERO_BYTE};
            push_frame(fr, 1'b1);
         end else begin
            v = longint'($signed(lin));
            w = longint'($signed(ang));
            den = 1;
            // turn limit scales v and w together
            if ((w < 0 ? -w : w) > longint'(turn_lim)) begin
               den = (w < 0 ? -w : w);
               v = v * longint'(turn_lim);
               w = w * longint'(turn_lim);
            end
            rn = 2000 * v + w * longint'(base_mm);
            ln = 2000 * v - w * longint'(base_mm);
            dd = 2000 * den;
            s  = longint'(wheel_lim) * dd;
            mr = rn < 0 ? -rn : rn;
            ml = ln < 0 ? -ln : ln;
            if (mr > s || ml > s) begin
               top = mr > ml ? mr : ml;
               dr = 16'(rn * longint'(full_scale) / top);
               dl = 16'(ln * longint'(full_scale) / top);
            end else if (s != 0) begin
               dr = 16'(rn * longint'(full_scale) / s);
               dl = 16'(ln * longint'(full_scale) / s);
            end else begin
               dr = '0;
               dl = '0;
            end
            fr = '{right_node, FUNC_WRITE_REG, speed_reg[15:8], speed_reg[7:0],
                   dr[15:8], dr[7:0]};
            push_frame(fr, 1'b0);
            fr = '{left_node, FUNC_WRITE_REG, speed_reg[15:8], speed_reg[7:0],
                   dl[15:8], dl[7:0]};
            push_frame(fr, 1'b1);
         end
      endfunction

      function void check_byte(logic [7:0] b, logic fe, logic lst);
         frame_byte_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected byte %h frame_end %b last %b", $time, b, fe, lst);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (b !== e.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, b);
            errors++;
         end
         if (fe !== e.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, fe);
            errors++;
         end
         if (lst !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [15:0] req_lin_vel;
   logic [15:0] req_ang_vel;
   logic [7:0]  req_coil_addr;
   logic [7:0]  req_coil_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard frames = new();
   bit              no_gaps;      // phases with back-to-back traffic on both sides
   int              cycles;

   diff_drive_modbus_command_framer_top dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_cmd, .req_lin_vel, .req_ang_vel,
      .req_coil_addr, .req_coil_value,
      .rsp_valid, .rsp_stall, .rsp_out_byte, .rsp_frame_end, .rsp_last,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // every accepted byte is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         frames.check_byte(rsp_out_byte, rsp_frame_end, rsp_last);
   end

   // receiver stalls at random before each byte, never while no_gaps is set
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // apb write with setup and access phases, register lands at the access edge
   task automatic write_reg(ddmcf_reg_type idx, logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 5'(4 * int'(idx));
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      frames.set_reg(idx, v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_all(logic [31:0] v[8]);
      for (int i = 0; i < 8; i++) write_reg(ddmcf_reg_type'(i), v[i]);
   endtask

   // one item: optional random sender gap unless no_gaps is set, then hold until accepted
   task automatic send_item(logic cmd, logic [15:0] lin, logic [15:0] ang,
                            logic [7:0] ca, logic [7:0] cv);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_lin_vel    <= lin;
      req_ang_vel    <= ang;
      req_coil_addr  <= ca;
      req_coil_value <= cv;
      do @(posedge clock); while (req_stall);
      frames.note_item(cmd, lin, ang, ca, cv);
      @(negedge clock);
   endtask

   // waits until every expected byte has come, then lets the pipe go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (frames.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly in-range speeds so the unlimited path is hit, the rest anywhere
   task automatic random_items(int count);
      logic [15:0] lin, ang;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            lin = 16'($urandom);
            ang = 16'($urandom);
         end else begin
            lin = 16'($signed($urandom_range(0, 3000)) - 1500);
            ang = 16'($signed($urandom_range(0, 4000)) - 2000);
         end
         send_item($urandom_range(0, 3) == 0 ? CMD_COIL : CMD_VELOCITY,
                   lin, ang, 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      logic [31:0] regs[8];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_VELOCITY;
      req_lin_vel    = '0;
      req_ang_vel    = '0;
      req_coil_addr  = '0;
      req_coil_value = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      no_gaps        = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed items on the reset settings
      send_item(CMD_VELOCITY, 16'sd0, 16'sd0, 8'hFF, 8'hFF);
      send_item(CMD_VELOCITY, 16'sd300, 16'sd200, 8'h00, 8'h00);     // no limiting
      send_item(CMD_VELOCITY, 16'sd32767, 16'sd0, 8'h5A, 8'hA5);     // wheel limit
      send_item(CMD_VELOCITY, -16'sd32768, 16'sd0, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd0, 16'sd32767, 8'h00, 8'h00);     // turn limit
      send_item(CMD_VELOCITY, 16'sd0, -16'sd32768, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd32767, 16'sd32767, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, -16'sd32768, -16'sd32768, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd1000, 16'sd0, 8'h00, 8'h00);      // exactly at limit
      send_item(CMD_VELOCITY, -16'sd1001, 16'sd1000, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, -16'sd1, 16'sd1, 8'h00, 8'h00);        // truncation toward zero
      send_item(CMD_COIL, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF);
      send_item(CMD_COIL, 16'h0000, 16'h0000, 8'hFF, 8'h00);
      send_item(CMD_COIL, 16'h8000, 16'h7FFF, 8'hAA, 8'h55);
      random_items(25);
      drain();

      // upper extremes of every register
      regs = '{32'h7FFF, 32'h7FFF, 32'hFFF, 32'h7FFF, 32'hFF, 32'hFF, 32'hFF, 32'hFFFF};
      write_all(regs);
      send_item(CMD_VELOCITY, 16'sd32767, 16'sd32767, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, -16'sd32768, 16'sd32767, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd32767, -16'sd32768, 8'h00, 8'h00);
      send_item(CMD_COIL, 16'h0000, 16'h0000, 8'h12, 8'hFF);
      random_items(25);
      drain();

      // lower extremes, back-to-back traffic
      no_gaps = 1'b1;
      regs = '{32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h0};
      write_all(regs);
      send_item(CMD_VELOCITY, 16'sd32767, -16'sd32768, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd1, 16'sd0, 8'h00, 8'h00);
      random_items(25);
      drain();
      no_gaps = 1'b0;

      // zero limits: a turn or zero speed gives zero drive, straight motion drives full scale
      regs = '{32'h0, 32'h0, 32'h1F4, 32'h3DE, 32'h2, 32'h1, 32'h4, 32'h40};
      write_all(regs);
      send_item(CMD_VELOCITY, 16'sd0, 16'sd0, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd500, 16'sd0, 8'h00, 8'h00);
      send_item(CMD_VELOCITY, 16'sd500, -16'sd7, 8'h00, 8'h00);
      random_items(10);
      drain();

      // random settings, upper bits included
      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < 8; i++) regs[i] = $urandom;
         write_all(regs);
         random_items(20);
         drain();
      end

      if (frames.errors == 0 && frames.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
src/ddmcf_pkg.sv
src/ddmcf_front.sv
src/ddmcf_div.sv
src/ddmcf_ser.sv
src/diff_drive_modbus_command_framer_top.sv
bench/tb_diff_drive_modbus_command_framer_top.sv
